### hdl/priority_event_queue_set_top_assert.svh
// Assertion macros for the priority event queue set checker.
// Depends on nothing; included by the checker file.
`ifndef PRIORITY_EVENT_QUEUE_SET_TOP_ASSERT_SVH
`define PRIORITY_EVENT_QUEUE_SET_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define PEQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PEQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### hdl/peqs_pkg.sv
// Shared constants and types of the priority event queue set.
// Depends on nothing.
package peqs_pkg;
    localparam int PRIORITIES  = 4;
    localparam int QUEUE_SIZE  = 16;
    localparam int EVENT_BYTES = 8;
    localparam int PW  = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam int IW  = $clog2(QUEUE_SIZE);
    localparam int SLOTS = PRIORITIES * QUEUE_SIZE;
    localparam int MEMW  = 64 + 8 + 4;
    localparam logic [4:0] QUOTA_CAP = 5'd16;

    localparam logic [1:0] CMD_PUBLISH = 2'd0;
    localparam logic [1:0] CMD_PROCESS = 2'd1;
    localparam logic [1:0] CMD_STATS   = 2'd2;

    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_FILTERED = 3'd3;
    localparam logic [2:0] ST_FAULT    = 3'd4;
    localparam logic [2:0] ST_EVENT    = 3'd5;
    localparam logic [2:0] ST_INFO     = 3'd6;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_QUOTA  = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [1:0] POL_DROP_OLDEST = 2'd1;
    localparam logic [1:0] POL_FAULT       = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  priority_req;
        logic [7:0]  type_id;
        logic [63:0] payload;
        logic [3:0]  size_bytes;
        logic        filter_pass;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_type_id;
        logic [2:0]  out_priority;
        logic [63:0] out_payload;
        logic [3:0]  out_len;
        logic [3:0]  queue_depth;
        logic [31:0] dropped_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic [8:0] data;
    } cfg_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic          latch_in;   // capture input beat, evaluate a command
        logic          pub_exec;   // perform the publish decided by datapath
        logic          rd_issue;   // issue memory read at scan priority
        logic          emit_event; // load result from memory data
        logic          emit_single;// load single result computed at latch
        logic          next_prio;  // advance scan priority, clear taken count
        logic          start_scan; // reset scan priority and count
        logic          set_last;   // value of last on emitted result
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_process;   // latched command is a non-faulted process round
        logic can_take;     // scan queue non-empty and quota left
        logic prio_done;    // scan priority is the final one
        logic any_emitted;  // an event was emitted this round
        logic more_after;   // some later event will follow the pending read
    } dp_stat_t;
endpackage

### hdl/peqs_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on peqs_pkg for the payload types.
interface peqs_in_if;
    logic valid;
    logic ready;
    peqs_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface peqs_out_if;
    logic valid;
    logic ready;
    peqs_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface peqs_cfg_if;
    logic valid;
    logic ready;
    peqs_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/peqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module peqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/peqs_datapath.sv
// Datapath: queue indexes, drop counters, slot memory and result register.
// Depends on peqs_pkg and peqs_ram.
module peqs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  peqs_pkg::in_item_t   in_data,
    input  peqs_pkg::ctl_cmd_t   ctl,
    input  logic                 cfg_we,
    input  peqs_pkg::cfg_item_t  cfg_data,
    output peqs_pkg::dp_stat_t   stat,
    output peqs_pkg::out_item_t  result
);
    localparam int PW = peqs_pkg::PW;
    localparam int IW = peqs_pkg::IW;

    logic [IW-1:0] wr_idx_reg [peqs_pkg::PRIORITIES];
    logic [IW-1:0] rd_idx_reg [peqs_pkg::PRIORITIES];
    logic [31:0]   drop_reg   [peqs_pkg::PRIORITIES];
    logic          fault_reg;
    logic [1:0]    policy_reg;
    logic [4:0]    quota_reg;
    logic [8:0]    limit_reg;

    peqs_pkg::in_item_t  item_reg, item_next;
    peqs_pkg::out_item_t single_reg, single_next, result_reg;
    logic          is_proc_reg, is_proc_next;
    logic          do_write_reg, do_write_next;
    logic          pop_old_reg, pop_old_next;
    logic          count_drop_reg, count_drop_next;
    logic          set_fault_next, set_fault_reg;
    logic [PW-1:0] scan_reg;
    logic [4:0]    taken_reg;
    logic          emitted_reg;
    logic [PW-1:0] rd_prio_reg;

    logic [peqs_pkg::MEMW-1:0] rdata;
    logic [PW-1:0] ip;
    logic          pvalid;
    logic [IW-1:0] wi, ri, wi1, depth_in;
    logic          full;
    logic [63:0]   masked;
    logic [4:0]    quota;
    logic [IW-1:0] sri;
    logic          scan_ne, can_take;
    logic          more_after;

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] v);
        if (int'(v) == peqs_pkg::QUEUE_SIZE - 1)
        begin
            return '0;
        end
        return v + IW'(1);
    endfunction

    // Evaluation of a fresh input beat.
    assign ip       = in_data.priority_req[PW-1:0];
    assign pvalid   = int'(in_data.priority_req) < peqs_pkg::PRIORITIES;
    assign wi       = wr_idx_reg[ip];
    assign ri       = rd_idx_reg[ip];
    assign wi1      = inc(wi);
    assign full     = wi1 == ri;
    assign depth_in = wi - ri;

    always_comb
    begin
        masked = in_data.payload;
        for (int b = 0; b < 8; b++)
        begin
            if (b >= int'(in_data.size_bytes))
            begin
                masked[8*b +: 8] = 8'h00;
            end
        end
        item_next         = in_data;
        item_next.payload = masked;
    end

    always_comb
    begin
        logic [IW-1:0] dep;
        logic [31:0]   drp;
        single_next     = '0;
        is_proc_next    = 1'b0;
        do_write_next   = 1'b0;
        pop_old_next    = 1'b0;
        count_drop_next = 1'b0;
        set_fault_next  = 1'b0;
        dep = depth_in;
        drp = drop_reg[ip];
        single_next.last = 1'b1;
        unique case (in_data.cmd)
            peqs_pkg::CMD_PUBLISH:
            begin
                single_next.out_type_id  = in_data.type_id;
                single_next.out_priority = in_data.priority_req;
                if (fault_reg)
                begin
                    single_next.status = peqs_pkg::ST_FAULT;
                end
                else if (in_data.size_bytes == 4'd0 ||
                         {1'b0, in_data.type_id} >= limit_reg || !pvalid)
                begin
                    single_next.status = peqs_pkg::ST_INVALID;
                end
                else if (!in_data.filter_pass)
                begin
                    single_next.status = peqs_pkg::ST_FILTERED;
                end
                else if (int'(in_data.size_bytes) > peqs_pkg::EVENT_BYTES)
                begin
                    single_next.status = peqs_pkg::ST_INVALID;
                end
                else if (full && policy_reg == peqs_pkg::POL_FAULT)
                begin
                    single_next.status = peqs_pkg::ST_FAULT;
                    set_fault_next = 1'b1;
                end
                else if (full && policy_reg != peqs_pkg::POL_DROP_OLDEST)
                begin
                    single_next.status = peqs_pkg::ST_DROPPED;
                    count_drop_next = 1'b1;
                    drp = drp + 32'd1;
                end
                else
                begin
                    single_next.status = peqs_pkg::ST_QUEUED;
                    do_write_next = 1'b1;
                    if (full)
                    begin
                        pop_old_next = 1'b1;
                        count_drop_next = 1'b1;
                        drp = drp + 32'd1;
                    end
                    else
                    begin
                        dep = dep + IW'(1);
                    end
                end
                single_next.queue_depth   = pvalid ? 4'(dep) : 4'd0;
                single_next.dropped_count = pvalid ? drp : 32'd0;
            end
            peqs_pkg::CMD_PROCESS:
            begin
                if (fault_reg)
                begin
                    single_next.status = peqs_pkg::ST_FAULT;
                end
                else
                begin
                    single_next.status = peqs_pkg::ST_INFO;
                    is_proc_next = 1'b1;
                end
            end
            peqs_pkg::CMD_STATS:
            begin
                single_next.out_priority = in_data.priority_req;
                if (pvalid)
                begin
                    single_next.status        = peqs_pkg::ST_INFO;
                    single_next.queue_depth   = 4'(dep);
                    single_next.dropped_count = drp;
                end
                else
                begin
                    single_next.status = peqs_pkg::ST_INVALID;
                end
            end
            default:
            begin
                single_next.status = peqs_pkg::ST_INVALID;
            end
        endcase
    end

    // Round scan.
    assign quota    = (quota_reg > peqs_pkg::QUOTA_CAP) ? peqs_pkg::QUOTA_CAP : quota_reg;
    assign sri      = rd_idx_reg[scan_reg];
    assign scan_ne  = wr_idx_reg[scan_reg] != sri;
    assign can_take = scan_ne && (taken_reg < quota);

    // A later event follows if this queue still has one within quota after
    // the pop, or any later queue holds one (quota is at least one then).
    always_comb
    begin
        logic later;
        later = 1'b0;
        for (int p = 0; p < peqs_pkg::PRIORITIES; p++)
        begin
            if (p > int'(scan_reg) && wr_idx_reg[p] != rd_idx_reg[p])
            begin
                later = 1'b1;
            end
        end
        more_after = (later && quota != 5'd0) ||
                     ((taken_reg + 5'd1 < quota) && (inc(sri) != wr_idx_reg[scan_reg]));
    end

    assign stat.more_after  = more_after;
    assign stat.is_process  = is_proc_reg;
    assign stat.can_take    = can_take;
    assign stat.prio_done   = int'(scan_reg) == peqs_pkg::PRIORITIES - 1;
    assign stat.any_emitted = emitted_reg;

    peqs_ram #(.WIDTH(peqs_pkg::MEMW), .DEPTH(peqs_pkg::SLOTS)) u_slots (
        .clk   (clk),
        .we    (ctl.pub_exec && do_write_reg),
        .waddr ({item_reg.priority_req[PW-1:0], wr_idx_reg[item_reg.priority_req[PW-1:0]]}),
        .wdata ({item_reg.payload, item_reg.type_id, item_reg.size_bytes}),
        .re    (ctl.rd_issue),
        .raddr ({scan_reg, sri}),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < peqs_pkg::PRIORITIES; p++)
            begin
                wr_idx_reg[p] <= '0;
                rd_idx_reg[p] <= '0;
                drop_reg[p]   <= '0;
            end
            fault_reg      <= 1'b0;
            policy_reg     <= 2'd0;
            quota_reg      <= 5'd4;
            limit_reg      <= 9'd32;
            is_proc_reg    <= 1'b0;
            do_write_reg   <= 1'b0;
            pop_old_reg    <= 1'b0;
            count_drop_reg <= 1'b0;
            set_fault_reg  <= 1'b0;
            scan_reg       <= '0;
            taken_reg      <= '0;
            emitted_reg    <= 1'b0;
            rd_prio_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_data.index)
                    peqs_pkg::REG_POLICY: policy_reg <= cfg_data.data[1:0];
                    peqs_pkg::REG_QUOTA:  quota_reg  <= cfg_data.data[4:0];
                    peqs_pkg::REG_LIMIT:  limit_reg  <= cfg_data.data;
                    default: ;
                endcase
            end
            if (ctl.latch_in)
            begin
                is_proc_reg    <= is_proc_next;
                do_write_reg   <= do_write_next;
                pop_old_reg    <= pop_old_next;
                count_drop_reg <= count_drop_next;
                set_fault_reg  <= set_fault_next;
            end
            if (ctl.pub_exec)
            begin
                if (do_write_reg)
                begin
                    wr_idx_reg[item_reg.priority_req[PW-1:0]] <=
                        inc(wr_idx_reg[item_reg.priority_req[PW-1:0]]);
                end
                if (pop_old_reg)
                begin
                    rd_idx_reg[item_reg.priority_req[PW-1:0]] <=
                        inc(rd_idx_reg[item_reg.priority_req[PW-1:0]]);
                end
                if (count_drop_reg)
                begin
                    drop_reg[item_reg.priority_req[PW-1:0]] <=
                        drop_reg[item_reg.priority_req[PW-1:0]] + 32'd1;
                end
                if (set_fault_reg)
                begin
                    fault_reg <= 1'b1;
                end
            end
            if (ctl.start_scan)
            begin
                scan_reg    <= '0;
                taken_reg   <= '0;
                emitted_reg <= 1'b0;
            end
            else if (ctl.next_prio)
            begin
                scan_reg  <= scan_reg + PW'(1);
                taken_reg <= '0;
            end
            else if (ctl.rd_issue)
            begin
                rd_idx_reg[scan_reg] <= inc(sri);
                taken_reg   <= taken_reg + 5'd1;
                emitted_reg <= 1'b1;
                rd_prio_reg <= scan_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            item_reg   <= item_next;
            single_reg <= single_next;
        end
        if (ctl.emit_single)
        begin
            result_reg <= single_reg;
        end
        else if (ctl.emit_event)
        begin
            result_reg.status        <= peqs_pkg::ST_EVENT;
            result_reg.out_type_id   <= rdata[11:4];
            result_reg.out_priority  <= 3'(rd_prio_reg);
            result_reg.out_payload   <= rdata[75:12];
            result_reg.out_len       <= rdata[3:0];
            result_reg.queue_depth   <= 4'(wr_idx_reg[rd_prio_reg] - rd_idx_reg[rd_prio_reg]);
            result_reg.dropped_count <= drop_reg[rd_prio_reg];
            result_reg.last          <= ctl.set_last;
        end
    end

    assign result = result_reg;
endmodule

### hdl/peqs_ctrl.sv
// Controller state machine sequencing commands, rounds and result beats.
// Depends on peqs_pkg.
module peqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  peqs_pkg::dp_stat_t  stat,
    output peqs_pkg::ctl_cmd_t  ctl
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_LOAD, S_HOLD} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   last_reg, last_next;

    // A result register slot is free when empty or being taken.
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ctl = '0;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        last_next       = last_reg;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_process)
                begin
                    ctl.start_scan = 1'b1;
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    ctl.pub_exec    = 1'b1;
                    ctl.emit_single = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.can_take)
                begin
                    ctl.rd_issue = 1'b1;
                    last_next = !stat.more_after;
                    state_next = S_LOAD;
                end
                else if (!stat.prio_done)
                begin
                    ctl.next_prio = 1'b1;
                end
                else if (!stat.any_emitted)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    ctl.emit_event = 1'b1;
                    ctl.set_last   = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = last_reg ? S_IDLE : S_SCAN;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    ctl.emit_single = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

### hdl/priority_event_queue_set_top.sv
// Top level of the priority event queue set: controller plus datapath.
// Depends on peqs_pkg, the channel interfaces, peqs_ctrl and peqs_datapath.
//
//  channel | role   | beat contents
//  in_ch   | sink   | cmd, priority_req, type_id, payload, size_bytes, filter_pass
//  out_ch  | source | status, ids, payload, length, depth, drops, last
//  cfg_ch  | sink   | register index and write data
//
// A publish, stats or unknown command is captured and evaluated, then
// committed as the result register is loaded. A process round is captured and
// started, then each delivered event takes a memory read followed by a result
// load, and each priority stepped past takes a scan step; an empty round ends
// in a single info result. The registered read of the slot memory splits the
// read and the load. Stalls on the result side hold the controller; input is
// taken only while idle. Reset clears indexes, drop counters, the fault flag
// and control state; slot contents and the result register stay undefined.
module priority_event_queue_set_top (
    input logic         clk,
    input logic         rst_n,
    peqs_in_if.sink     in_ch,
    peqs_out_if.source  out_ch,
    peqs_cfg_if.sink    cfg_ch
);
    peqs_pkg::ctl_cmd_t ctl;
    peqs_pkg::dp_stat_t stat;

    // Configuration writes are always accepted; the block is idle by contract.
    assign cfg_ch.ready = 1'b1;

    peqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    peqs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_ch.data),
        .ctl      (ctl),
        .cfg_we   (cfg_ch.valid),
        .cfg_data (cfg_ch.data),
        .stat     (stat),
        .result   (out_ch.data)
    );
endmodule

### hdl/peqs_checker.sv
// Port-level checker for the priority event queue set, with its bind.
// Depends on peqs_pkg and priority_event_queue_set_top_assert.svh.
`include "priority_event_queue_set_top_assert.svh"
module peqs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input peqs_pkg::out_item_t out_data
);
    `PEQ_ASSERT_NEXT(a_in_then_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `PEQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `PEQ_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid && !out_ready && !out_data.last, !in_ready)
    `PEQ_ASSERT_IMP(a_event_payload, clk, rst_n, out_valid && out_data.status != peqs_pkg::ST_EVENT, out_data.out_payload == 64'd0)
endmodule

bind priority_event_queue_set_top peqs_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

### dv/tb_priority_event_queue_set_top.sv
// Self-checking testbench of priority_event_queue_set_top: directed table, then random phases.
// Depends on peqs_pkg, the peqs channel interfaces and the top level RTL.
module tb_priority_event_queue_set_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names the three valid commands only; the fourth code is undefined.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] POL_DROP_NEWEST = 2'd0;

    typedef struct {
        peqs_pkg::in_item_t  beat;
        bit                  typed;
        peqs_pkg::out_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    bit   failed;

    peqs_in_if  in_ch();
    peqs_out_if out_ch();
    peqs_cfg_if cfg_ch();

    priority_event_queue_set_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Mirror of the queue contents and the register settings.
    logic [63:0] mir_payload [peqs_pkg::PRIORITIES][peqs_pkg::QUEUE_SIZE];
    logic [7:0]  mir_id      [peqs_pkg::PRIORITIES][peqs_pkg::QUEUE_SIZE];
    logic [3:0]  mir_size    [peqs_pkg::PRIORITIES][peqs_pkg::QUEUE_SIZE];
    int unsigned mir_wr      [peqs_pkg::PRIORITIES];
    int unsigned mir_rd      [peqs_pkg::PRIORITIES];
    logic [31:0] mir_drops   [peqs_pkg::PRIORITIES];
    bit          mir_fault;
    logic [1:0]  cur_policy;
    logic [4:0]  cur_quota;
    logic [8:0]  cur_limit;

    // Results still owed by the block, oldest first.
    peqs_pkg::out_item_t pending_results[$];

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned depth_of(int unsigned p);
        return (mir_wr[p] + peqs_pkg::QUEUE_SIZE - mir_rd[p]) % peqs_pkg::QUEUE_SIZE;
    endfunction

    function automatic peqs_pkg::out_item_t make_result(logic [2:0] st, logic [7:0] id,
                                                        logic [2:0] pr, logic [3:0] dep,
                                                        logic [31:0] drp);
        peqs_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.out_type_id = id;
        r.out_priority = pr;
        r.queue_depth = dep;
        r.dropped_count = drp;
        r.last = 1'b1;
        return r;
    endfunction

    // Queue one event; returns the publish status.
    function automatic logic [2:0] enqueue_event(peqs_pkg::in_item_t b);
        int unsigned p;
        logic [63:0] data;
        p = b.priority_req;
        if (b.size_bytes == 0 || {1'b0, b.type_id} >= cur_limit || p >= peqs_pkg::PRIORITIES)
            return peqs_pkg::ST_INVALID;
        if (!b.filter_pass)
            return peqs_pkg::ST_FILTERED;
        if (b.size_bytes > peqs_pkg::EVENT_BYTES)
            return peqs_pkg::ST_INVALID;
        if ((mir_wr[p] + 1) % peqs_pkg::QUEUE_SIZE == mir_rd[p])
        begin
            if (cur_policy == peqs_pkg::POL_DROP_OLDEST)
            begin
                mir_rd[p] = (mir_rd[p] + 1) % peqs_pkg::QUEUE_SIZE;
                mir_drops[p] = mir_drops[p] + 1;
            end
            else if (cur_policy == peqs_pkg::POL_FAULT)
            begin
                mir_fault = 1'b1;
                return peqs_pkg::ST_FAULT;
            end
            else
            begin
                mir_drops[p] = mir_drops[p] + 1;
                return peqs_pkg::ST_DROPPED;
            end
        end
        data = b.payload;
        if (b.size_bytes < 8)
            data = data & ((64'd1 << (8 * b.size_bytes)) - 64'd1);
        mir_payload[p][mir_wr[p]] = data;
        mir_id[p][mir_wr[p]] = b.type_id;
        mir_size[p][mir_wr[p]] = b.size_bytes;
        mir_wr[p] = (mir_wr[p] + 1) % peqs_pkg::QUEUE_SIZE;
        return peqs_pkg::ST_QUEUED;
    endfunction

    // Updates the mirror for one accepted beat and appends the results it causes.
    task automatic predict_results(peqs_pkg::in_item_t b);
        peqs_pkg::out_item_t r;
        logic [2:0] st;
        int unsigned quota;
        int unsigned taken;
        int unsigned slot;
        int n;
        bit pvalid;
        pvalid = b.priority_req < peqs_pkg::PRIORITIES;
        n = 0;
        if (b.cmd == peqs_pkg::CMD_PUBLISH)
        begin
            st = mir_fault ? peqs_pkg::ST_FAULT : enqueue_event(b);
            pending_results.push_back(make_result(st, b.type_id, b.priority_req,
                pvalid ? 4'(depth_of(b.priority_req)) : 4'd0,
                pvalid ? mir_drops[b.priority_req] : 32'd0));
        end
        else if (b.cmd == peqs_pkg::CMD_PROCESS)
        begin
            if (mir_fault)
                pending_results.push_back(make_result(peqs_pkg::ST_FAULT, 0, 0, 0, 0));
            else
            begin
                quota = (cur_quota > peqs_pkg::QUOTA_CAP) ? peqs_pkg::QUOTA_CAP : cur_quota;
                for (int p = 0; p < peqs_pkg::PRIORITIES; p++)
                begin
                    taken = 0;
                    while (taken < quota && mir_wr[p] != mir_rd[p])
                    begin
                        slot = mir_rd[p];
                        mir_rd[p] = (mir_rd[p] + 1) % peqs_pkg::QUEUE_SIZE;
                        r = make_result(peqs_pkg::ST_EVENT, mir_id[p][slot], 3'(p),
                                        4'(depth_of(p)), mir_drops[p]);
                        r.out_payload = mir_payload[p][slot];
                        r.out_len = mir_size[p][slot];
                        r.last = 1'b0;
                        pending_results.push_back(r);
                        n++;
                        taken++;
                    end
                end
                // Only the final event of the round carries last.
                if (n == 0)
                    pending_results.push_back(make_result(peqs_pkg::ST_INFO, 0, 0, 0, 0));
                else
                    pending_results[$].last = 1'b1;
            end
        end
        else if (b.cmd == peqs_pkg::CMD_STATS)
        begin
            if (pvalid)
                pending_results.push_back(make_result(peqs_pkg::ST_INFO, 0, b.priority_req,
                    4'(depth_of(b.priority_req)), mir_drops[b.priority_req]));
            else
                pending_results.push_back(make_result(peqs_pkg::ST_INVALID, 0,
                                                      b.priority_req, 0, 0));
        end
        else
            pending_results.push_back(make_result(peqs_pkg::ST_INVALID, 0, 0, 0, 0));
    endtask

    // Offers one beat and holds valid until the block takes it; valid stays up afterwards.
    task automatic send_beat(peqs_pkg::in_item_t b);
        in_ch.data <= b;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_results(b);
    endtask

    // Random gap after a beat, per the current idling phase.
    task automatic sender_gap();
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Register writes happen only once every owed result has come back.
    task automatic write_register(logic [1:0] idx, logic [8:0] value);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_ch.data <= '{index: idx, data: value};
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == peqs_pkg::REG_POLICY)
            cur_policy = value[1:0];
        else if (idx == peqs_pkg::REG_QUOTA)
            cur_quota = value[4:0];
        else if (idx == peqs_pkg::REG_LIMIT)
            cur_limit = value;
    endtask

    function automatic peqs_pkg::in_item_t make_beat(logic [1:0] c, logic [2:0] pr,
                                                     logic [7:0] id, logic [63:0] pl,
                                                     logic [3:0] sz, logic pass);
        peqs_pkg::in_item_t b;
        b.cmd = c;
        b.priority_req = pr;
        b.type_id = id;
        b.payload = pl;
        b.size_bytes = sz;
        b.filter_pass = pass;
        return b;
    endfunction

    // Random beat. Well-formed publishes dominate so that queues fill and overflow;
    // hot_prio steers most of them to one queue.
    function automatic peqs_pkg::in_item_t random_beat(int hot_prio);
        peqs_pkg::in_item_t b;
        int pick;
        pick = $urandom_range(99);
        b.cmd = (pick < 62) ? peqs_pkg::CMD_PUBLISH : (pick < 82) ? peqs_pkg::CMD_PROCESS :
                (pick < 96) ? peqs_pkg::CMD_STATS : CMD_UNKNOWN;
        if ($urandom_range(9) == 0)
            b.priority_req = 3'($urandom_range(7));
        else if (hot_prio >= 0 && $urandom_range(1))
            b.priority_req = 3'(hot_prio);
        else
            b.priority_req = 3'($urandom_range(peqs_pkg::PRIORITIES - 1));
        if ($urandom_range(9) == 0 || cur_limit > 255)
            b.type_id = 8'($urandom_range(255));
        else
            b.type_id = 8'($urandom_range(cur_limit - 1));
        b.payload = {$urandom, $urandom};
        b.size_bytes = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                                   4'($urandom_range(1, 8));
        b.filter_pass = ($urandom_range(9) != 0);
        return b;
    endfunction

    // Result side: checks every accepted beat, then picks ready for the next edge.
    always @(posedge clk)
    begin
        peqs_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, out_ch.data);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data !== want)
                begin
                    $display("%0t: result differs, expected %p actual %p",
                             $time, want, out_ch.data);
                    failed = 1'b1;
                end
            end
        end
        // A long hold-off stalls the result side and so the block's input side.
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the whole run.
    initial
    begin
        #20ms;
        $display("priority_event_queue_set_top: mismatch");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        logic [1:0] policies[8];
        logic [4:0] quotas[8];
        logic [8:0] limits[8];
        int hot;

        clk = 1'b0;
        rst_n = 1'b0;
        failed = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        for (int p = 0; p < peqs_pkg::PRIORITIES; p++)
        begin
            mir_wr[p] = 0;
            mir_rd[p] = 0;
            mir_drops[p] = '0;
        end
        mir_fault = 1'b0;
        cur_policy = POL_DROP_NEWEST;
        cur_quota = 5'd4;
        cur_limit = 9'd32;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: fixed answers where they are obvious, predictor elsewhere.
        rows.push_back('{make_beat(peqs_pkg::CMD_STATS, 0, 0, 0, 0, 1), 1,
                         make_result(peqs_pkg::ST_INFO, 0, 0, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PROCESS, 0, 0, 0, 0, 1), 1,
                         make_result(peqs_pkg::ST_INFO, 0, 0, 0, 0)});
        rows.push_back('{make_beat(CMD_UNKNOWN, 5, 9, '1, 3, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 2, 3, '1, 0, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 3, 2, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 1, 255, '1, 4, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 255, 1, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 7, 1, '1, 1, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 1, 7, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 1, 2, '1, 3, 0), 1,
                         make_result(peqs_pkg::ST_FILTERED, 2, 1, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 1, 2, '1, 9, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 2, 1, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 1, 2, '1, 15, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 2, 1, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_STATS, 4, 0, 0, 0, 1), 1,
                         make_result(peqs_pkg::ST_INVALID, 0, 4, 0, 0)});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 0, 31, '1, 8, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 3, 0, '1, 1, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 1, 17, 64'h0123_4567_89ab_cdef, 5, 1),
                         0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 2, 8, '0, 8, 1), 0, '0});
        for (int i = 0; i < 6; i++)
            rows.push_back('{make_beat(peqs_pkg::CMD_PUBLISH, 0, 8'(i), {$urandom, $urandom},
                                       7, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_STATS, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_PROCESS, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_PROCESS, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_beat(peqs_pkg::CMD_STATS, 3, 0, 0, 0, 1), 0, '0});

        foreach (rows[i])
        begin
            send_beat(rows[i].beat);
            if (rows[i].typed)
                pending_results[$] = rows[i].want;
        end

        // Register settings per phase; the sticky fault policy comes last since
        // only reset clears a fault.
        policies = '{POL_DROP_NEWEST, peqs_pkg::POL_DROP_OLDEST, POL_DROP_NEWEST,
                     peqs_pkg::POL_DROP_OLDEST, POL_DROP_NEWEST, peqs_pkg::POL_DROP_OLDEST,
                     POL_DROP_NEWEST, peqs_pkg::POL_FAULT};
        quotas   = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd4, 5'd1};
        limits   = '{9'd256, 9'd1, 9'd256, 9'd511, 9'd32, 9'd256, 9'd100, 9'd256};

        for (int ph = 0; ph < 8; ph++)
        begin
            write_register(peqs_pkg::REG_POLICY, {7'd0, policies[ph]});
            write_register(peqs_pkg::REG_QUOTA, {4'd0, quotas[ph]});
            write_register(peqs_pkg::REG_LIMIT, limits[ph]);
            case (ph % 5)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
                3: begin sender_idle_pct = 34; recv_stall_pct = 34; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            hot = $urandom_range(peqs_pkg::PRIORITIES - 1);
            // One phase holds the result side off while beats keep coming.
            if (ph == 5)
                hold_request = 1'b1;
            for (int i = 0; i < 40; i++)
            begin
                send_beat(random_beat(hot));
                sender_gap();
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (!failed)
            $display("priority_event_queue_set_top: match");
        else
            $display("priority_event_queue_set_top: mismatch");
        $finish;
    end
endmodule
